/* hdl/sbsm_pkg.sv */
// Shared types and codes for the serial bank switch mapper.
// Used by every module of the block. It has no dependencies.
package sbsm_pkg;

  typedef enum logic [1:0] {
    OP_CPU_READ  = 2'd0,
    OP_CPU_WRITE = 2'd1,
    OP_VIDEO     = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_WORK_RAM  = 3'd1,
    TGT_PRG_ROM   = 3'd2,
    TGT_VIDEO     = 3'd3,
    TGT_NAMETABLE = 3'd4,
    TGT_MAPPER    = 3'd5
  } target_e;

  typedef enum logic [2:0] {
    LD_NONE    = 3'd0,
    LD_CONTROL = 3'd1,
    LD_VBANK0  = 3'd2,
    LD_VBANK1  = 3'd3,
    LD_PROGRAM = 3'd4
  } loaded_e;

  // configuration register index
  typedef enum logic [1:0] {
    CFG_VIDEO_MASK = 2'd0,
    CFG_ROM_512K   = 2'd1,
    CFG_LAST_BANK  = 2'd2,
    CFG_WRAM_MODE  = 2'd3
  } cfg_idx_e;

  // destination of a completed serial load, address bits 14..13
  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_VBANK0  = 2'd1,
    SEL_VBANK1  = 2'd2,
    SEL_PROGRAM = 2'd3
  } port_sel_e;

  typedef enum logic [2:0] {
    WRAM_NONE = 3'd0,
    WRAM_8K   = 3'd1,
    WRAM_16K  = 3'd2,
    WRAM_32K  = 3'd3,
    WRAM_DUAL = 3'd4
  } wram_mode_e;

  localparam logic [2:0] ShiftLen     = 3'd5;
  localparam logic [4:0] CtrlReset    = 5'h0C;
  localparam logic [4:0] CtrlPrgModes = 5'h0C;
  localparam logic [7:0] VideoTopPage = 8'h3F;

  typedef struct packed {
    logic [4:0] video_mask;
    logic       rom_512k;
    logic [4:0] top_bank;
    logic [2:0] wram_mode;
  } cfg_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] vbank0;
    logic [4:0] vbank1;
    logic [4:0] prog_sel;
  } regs_t;

endpackage

/* hdl/sbsm_serial.sv */
// Serial register port: five-write shifter, write spacing check and bank registers.
// Depends on sbsm_pkg.
module sbsm_serial (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           value_i,
  input  logic [63:0]          now_i,
  output sbsm_pkg::regs_t      regs_o,
  output logic [4:0]           control_next_o,
  output sbsm_pkg::loaded_e    loaded_o
);

  logic [2:0]      cnt_q, cnt_d, cnt_inc;
  logic [4:0]      bits_q, bits_d, bits_new;
  // time of the previous serial data write (bit 7 clear) plus one, wrapping at 64 bits
  logic [63:0]     last_q, last_d;
  sbsm_pkg::regs_t regs_q, regs_d;

  always_comb begin
    cnt_d    = cnt_q;
    bits_d   = bits_q;
    last_d   = last_q;
    regs_d   = regs_q;
    loaded_o = sbsm_pkg::LD_NONE;
    cnt_inc  = 3'(cnt_q + 3'd1);
    bits_new = bits_q | (5'(value_i[0]) << cnt_q);
    if (wr_en_i) begin
      if (value_i[7]) begin
        cnt_d          = '0;
        bits_d         = '0;
        regs_d.control = regs_q.control | sbsm_pkg::CtrlPrgModes;
      end else begin
        last_d = 64'(now_i + 64'd1);
        // writes on adjacent cycles are dropped
        if (last_q < now_i) begin
          if (cnt_inc == sbsm_pkg::ShiftLen) begin
            cnt_d  = '0;
            bits_d = '0;
            unique case (sbsm_pkg::port_sel_e'(addr_i[14:13]))
              sbsm_pkg::SEL_CONTROL: begin
                regs_d.control = bits_new;
                loaded_o       = sbsm_pkg::LD_CONTROL;
              end
              sbsm_pkg::SEL_VBANK0: begin
                regs_d.vbank0 = bits_new;
                loaded_o      = sbsm_pkg::LD_VBANK0;
              end
              sbsm_pkg::SEL_VBANK1: begin
                regs_d.vbank1 = bits_new;
                loaded_o      = sbsm_pkg::LD_VBANK1;
              end
              default: begin
                regs_d.prog_sel = bits_new;
                loaded_o        = sbsm_pkg::LD_PROGRAM;
              end
            endcase
          end else begin
            cnt_d  = cnt_inc;
            bits_d = bits_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q           <= '0;
      bits_q          <= '0;
      last_q          <= 64'd1;
      regs_q.control  <= sbsm_pkg::CtrlReset;
      regs_q.vbank0   <= '0;
      regs_q.vbank1   <= '0;
      regs_q.prog_sel <= '0;
    end else begin
      cnt_q  <= cnt_d;
      bits_q <= bits_d;
      last_q <= last_d;
      regs_q <= regs_d;
    end
  end

  assign regs_o         = regs_q;
  assign control_next_o = regs_d.control;

endmodule

/* hdl/sbsm_map.sv */
// Address decode and bank mapping for work RAM, program ROM and video memory.
// Depends on sbsm_pkg.
module sbsm_map (
  input  logic [1:0]       op_i,
  input  logic [15:0]      addr_i,
  input  sbsm_pkg::cfg_t   cfg_i,
  input  sbsm_pkg::regs_t  regs_i,
  output logic [2:0]       target_o,
  output logic [18:0]      mapped_addr_o
);

  logic [1:0]  wram_bank;
  logic [14:0] wram_addr;
  logic        ext;
  logic [4:0]  sel, first, last, rom_bank;
  logic [18:0] prg_addr;
  logic [4:0]  vb_lo_m, vb_hi_m, vb_4k;
  logic [16:0] vid_addr;

  always_comb begin
    unique case (sbsm_pkg::wram_mode_e'(cfg_i.wram_mode))
      sbsm_pkg::WRAM_DUAL: wram_bank = {1'b0, regs_i.vbank0[4]};
      sbsm_pkg::WRAM_16K:  wram_bank = {1'b0, regs_i.vbank0[3]};
      sbsm_pkg::WRAM_32K:  wram_bank = regs_i.vbank0[3:2];
      default:             wram_bank = 2'd0;
    endcase
    wram_addr = {wram_bank, addr_i[12:0]};
  end

  always_comb begin
    ext   = cfg_i.rom_512k & regs_i.vbank0[4];
    sel   = {ext, regs_i.prog_sel[3:0]};
    first = {ext, 4'd0};
    last  = cfg_i.top_bank & {ext, 4'hF};
    rom_bank = sel;
    if (regs_i.control[3:2] == 2'd2 && !addr_i[14]) begin
      rom_bank = first;
    end else if (regs_i.control[3:2] == 2'd3 && addr_i[14]) begin
      rom_bank = last;
    end
    // 32K modes ignore the low bank bit
    if (!regs_i.control[3]) begin
      prg_addr = {sel[4:1], addr_i[14:0]};
    end else begin
      prg_addr = {rom_bank, addr_i[13:0]};
    end
  end

  always_comb begin
    vb_lo_m = regs_i.vbank0 & cfg_i.video_mask;
    vb_hi_m = regs_i.vbank1 & cfg_i.video_mask;
    vb_4k   = addr_i[12] ? vb_hi_m : vb_lo_m;
    if (!regs_i.control[4]) begin
      vid_addr = {vb_lo_m[4:1], addr_i[12:0]};
    end else begin
      vid_addr = {vb_4k, addr_i[11:0]};
    end
  end

  always_comb begin
    target_o      = sbsm_pkg::TGT_NONE;
    mapped_addr_o = '0;
    unique case (sbsm_pkg::op_e'(op_i))
      sbsm_pkg::OP_CPU_READ, sbsm_pkg::OP_CPU_WRITE: begin
        if (addr_i[15]) begin
          if (op_i == sbsm_pkg::OP_CPU_READ) begin
            target_o      = sbsm_pkg::TGT_PRG_ROM;
            mapped_addr_o = prg_addr;
          end else begin
            target_o = sbsm_pkg::TGT_MAPPER;
          end
        end else if (addr_i[14:13] == 2'b11 && cfg_i.wram_mode != sbsm_pkg::WRAM_NONE) begin
          target_o      = sbsm_pkg::TGT_WORK_RAM;
          mapped_addr_o = 19'(wram_addr);
        end
      end
      sbsm_pkg::OP_VIDEO: begin
        if (addr_i[15:13] == 3'd0) begin
          target_o      = sbsm_pkg::TGT_VIDEO;
          mapped_addr_o = 19'(vid_addr);
        end else if (addr_i[15:8] < sbsm_pkg::VideoTopPage) begin
          target_o = sbsm_pkg::TGT_NAMETABLE;
        end
      end
      default: begin
        target_o = sbsm_pkg::TGT_NONE;
      end
    endcase
  end

endmodule

/* hdl/serial_bank_switch_mapper_unit.sv */
// Top level of the serial bank switch mapper: input register, mapping, result register.
// Depends on sbsm_pkg, sbsm_serial and sbsm_map.
//
// Usage: every bus access is one transaction on the input channel (in_valid_i /
// in_ready_o): op, bus address, written byte and CPU cycle count. Each access
// produces exactly one result transaction on the output channel (out_valid_o /
// out_ready_i): target memory, offset inside it, current mirroring code and the
// register loaded by this access, if any.
// The result passes through the input register and then the result register
// before it is offered on the output channel.
// Throughput is one transaction per cycle while the receiver does not stall; the
// mapping and the serial port update sit between those two registers.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o drops only when both are occupied, so no transaction is lost.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect on the
// next cycle and are meant to be issued while no transaction is in flight.
// Reset empties both registers, clears the serial shifter and bank registers,
// sets the control register to its program-mode default and loads the default
// configuration.
module serial_bank_switch_mapper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] bus_addr_i,
  input  logic [7:0]  write_value_i,
  input  logic [63:0] cpu_cycle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  target_o,
  output logic [18:0] mapped_addr_o,
  output logic [1:0]  mirroring_o,
  output logic [2:0]  loaded_register_o
);

  sbsm_pkg::cfg_t    cfg_q;
  sbsm_pkg::regs_t   regs;
  sbsm_pkg::loaded_e loaded;

  logic        in_valid_q;
  logic [1:0]  op_q;
  logic [15:0] addr_q;
  logic [7:0]  wval_q;
  logic [63:0] cyc_q;

  logic        out_valid_q;
  logic [2:0]  target_q;
  logic [18:0] mapped_q;
  logic [1:0]  mirror_q;
  logic [2:0]  loaded_q;

  logic        advance, fire, ser_wr;
  logic [4:0]  control_next;
  logic [2:0]  target;
  logic [18:0] mapped;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign ser_wr     = fire && op_q == sbsm_pkg::OP_CPU_WRITE && addr_q[15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.video_mask <= 5'd31;
      cfg_q.rom_512k   <= 1'b0;
      cfg_q.top_bank   <= 5'd15;
      cfg_q.wram_mode  <= sbsm_pkg::WRAM_8K;
    end else if (cfg_we_i) begin
      unique case (sbsm_pkg::cfg_idx_e'(cfg_index_i))
        sbsm_pkg::CFG_VIDEO_MASK: cfg_q.video_mask <= cfg_wdata_i;
        sbsm_pkg::CFG_ROM_512K:   cfg_q.rom_512k   <= cfg_wdata_i[0];
        sbsm_pkg::CFG_LAST_BANK:  cfg_q.top_bank   <= cfg_wdata_i;
        default:                  cfg_q.wram_mode  <= cfg_wdata_i[2:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= op_i;
      addr_q <= bus_addr_i;
      wval_q <= write_value_i;
      cyc_q  <= cpu_cycle_i;
    end
  end

  sbsm_serial u_serial (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (ser_wr),
    .addr_i         (addr_q),
    .value_i        (wval_q),
    .now_i          (cyc_q),
    .regs_o         (regs),
    .control_next_o (control_next),
    .loaded_o       (loaded)
  );

  sbsm_map u_map (
    .op_i          (op_q),
    .addr_i        (addr_q),
    .cfg_i         (cfg_q),
    .regs_i        (regs),
    .target_o      (target),
    .mapped_addr_o (mapped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      target_q <= target;
      mapped_q <= mapped;
      mirror_q <= control_next[1:0];
      loaded_q <= loaded;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign target_o          = target_q;
  assign mapped_addr_o     = mapped_q;
  assign mirroring_o       = mirror_q;
  assign loaded_register_o = loaded_q;

endmodule

/* hdl/sbsm_checker.sv */
// Port-level checks for serial_bank_switch_mapper_unit, bound to the top level.
// Depends on sbsm_pkg.
module sbsm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] bus_addr_i,
  input  logic [7:0]  write_value_i,
  input  logic [63:0] cpu_cycle_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [2:0]  target_o,
  input  logic [18:0] mapped_addr_o,
  input  logic [1:0]  mirroring_o,
  input  logic [2:0]  loaded_register_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_o)
      && $stable(mapped_addr_o) && $stable(loaded_register_o))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_load_is_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loaded_register_o != sbsm_pkg::LD_NONE
      |-> target_o == sbsm_pkg::TGT_MAPPER)
    else $error("register load reported outside a mapper write");

  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_o == sbsm_pkg::TGT_NONE || target_o == sbsm_pkg::TGT_NAMETABLE
      || target_o == sbsm_pkg::TGT_MAPPER) |-> mapped_addr_o == 19'd0)
    else $error("offset reported for a target without memory");

  a_video_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == sbsm_pkg::TGT_VIDEO |-> mapped_addr_o[18:17] == 2'd0)
    else $error("video offset out of range");

endmodule

bind serial_bank_switch_mapper_unit sbsm_checker u_sbsm_checker (.*);
